>>> rtl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
package ptt_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MASK_W          = 8;
  localparam int SLOT_W          = 3;
  localparam int KIND_W          = 3;
  localparam int PERIOD_W        = 32;
  localparam int STATUS_W        = 2;
  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = 8;
  localparam int OUT_TDATA_W     = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 3'd0,
    KIND_SET      = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_RESUME   = 3'd3,
    KIND_DELETE   = 3'd4,
    KIND_STOP_ALL = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  // Command held steady while its token walks the row of cells
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              per_zero;
  } cmd_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] enabled;
  } tok_t;

endpackage

>>> rtl/ptt_cell.sv
// One timer slot: holds its period, countdown and marks, and passes the token on.
module ptt_cell
  import ptt_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd_i,
  input  logic [COUNT_WIDTH-1:0] period_i,
  input  tok_t                   tok_i,
  output tok_t                   tok_o
);

  logic [COUNT_WIDTH-1:0] period_r, period_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   in_use_r, in_use_nxt;
  logic                   en_r, en_nxt;
  tok_t                   tok_r, tok_nxt;
  logic                   match;
  logic                   fire;

  assign match = ({4'b0, cmd_i.slot} == 7'(IDX));

  always_comb begin
    period_nxt = period_r;
    count_nxt  = count_r;
    in_use_nxt = in_use_r;
    en_nxt     = en_r;
    tok_nxt    = tok_i;
    fire       = 1'b0;
    if (tok_i.valid) begin
      unique case (cmd_i.kind)
        KIND_TICK: begin
          if (in_use_r && en_r) begin
            if (count_r <= COUNT_WIDTH'(1)) begin
              count_nxt = period_r;
              fire      = 1'b1;
            end else begin
              count_nxt = count_r - COUNT_WIDTH'(1);
            end
          end
        end
        KIND_SET: begin
          if (match && !cmd_i.per_zero) begin
            if (!in_use_r) begin
              in_use_nxt = 1'b1;
              en_nxt     = 1'b1;
            end
            period_nxt  = period_i;
            count_nxt   = period_i;
            tok_nxt.hit = 1'b1;
          end
        end
        KIND_STOP: begin
          if (match && in_use_r) begin
            en_nxt      = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        KIND_RESUME: begin
          if (match && in_use_r) begin
            en_nxt      = 1'b1;
            count_nxt   = period_r;
            tok_nxt.hit = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (match && in_use_r) begin
            in_use_nxt  = 1'b0;
            en_nxt      = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        KIND_STOP_ALL: begin
          en_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // only the first eight slots show in the masks
      if (IDX < MASK_W) begin
        tok_nxt.fired[IDX % MASK_W]   = tok_i.fired[IDX % MASK_W] | fire;
        tok_nxt.enabled[IDX % MASK_W] = in_use_nxt & en_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      en_r     <= 1'b0;
      tok_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      en_r     <= en_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    count_r  <= count_nxt;
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/periodic_timer_table.sv
// Top level of the periodic timer table: command intake, row of slot cells, result register.
//
//   channel   dir   beat contents
//   in_       in    tuser: kind[2:0]; tdata: slot[2:0], period[34:3], zeros to bit 39
//   out_      out   tdata: fired_mask[7:0], enabled_mask[15:8], status[17:16], zeros to 23
//
// Each item's token walks the row of cells, one slot a cycle, then the result is
// latched and moved to the output register.
// Reset clears the in-use and enable marks of every slot and the control state.
// A result waiting on out_tready does not block the next item being taken; a
// further result is held until the output register frees up.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot[2:0], period[34:3]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // fired_mask[7:0], enabled_mask[15:8], status[17:16]
);

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r;
  logic [COUNT_WIDTH-1:0] period_r;
  logic                   head_r;
  tok_t                   chain [NUM_SLOTS+1];
  logic [OUT_TDATA_W-1:0] res_r, res_nxt;
  logic [OUT_TDATA_W-1:0] out_r;
  logic                   out_valid_r;
  logic                   accept;
  logic                   load_out;
  logic [63:0]            period_ext;
  logic [COUNT_WIDTH-1:0] period_in;
  status_t                status;

  assign period_ext = 64'(in_tdata[SLOT_W +: PERIOD_W]);
  assign period_in  = period_ext[COUNT_WIDTH-1:0];
  assign accept     = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RUN;
      S_RUN:  if (chain[NUM_SLOTS].valid) state_nxt = S_HOLD;
      S_HOLD: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_RUN:   ;
      S_HOLD:  load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (cmd_r.kind == KIND_SET && cmd_r.per_zero) begin
      status = ST_ZERO;
    end else if ((cmd_r.kind == KIND_SET || cmd_r.kind == KIND_STOP ||
                  cmd_r.kind == KIND_RESUME || cmd_r.kind == KIND_DELETE) &&
                 !chain[NUM_SLOTS].hit) begin
      status = ST_ABSENT;
    end
    res_nxt = {6'b0, status, chain[NUM_SLOTS].enabled, chain[NUM_SLOTS].fired};
  end

  assign chain[0] = '{valid: head_r, hit: 1'b0, fired: '0, enabled: '0};

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptt_cell #(
      .IDX         (i),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd_i    (cmd_r),
      .period_i (period_r),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= accept;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.kind     <= in_tuser[KIND_W-1:0];
      cmd_r.slot     <= in_tdata[SLOT_W-1:0];
      cmd_r.per_zero <= (period_in == '0);
      period_r       <= period_in;
    end
    if (state_r == S_RUN && chain[NUM_SLOTS].valid) begin
      res_r <= res_nxt;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
